// ----- hw/rtl/wsg_pkg.sv -----
// Shared constants, types and arithmetic helpers for the warp source coordinate generator.
package wsg_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int MAX_DIM    = 4096;
    localparam int COORD_W    = 12;
    localparam int COEF_W     = 18;
    localparam int BIAS_W     = 26;
    localparam int SIZE_W     = 13;
    localparam int PROD_W     = COEF_W + COORD_W + 1;
    localparam int VAL_W      = 34;
    localparam int K_W        = 20;
    localparam int MOD_W      = SIZE_W;
    localparam int MOD_STAGES = K_W - 1;
    localparam int INDEX_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int IDXP_W     = COORD_W + SIZE_W;

    localparam logic [1:0] BORDER_CROP    = 2'd0;
    localparam logic [1:0] BORDER_CLAMP   = 2'd1;
    localparam logic [1:0] BORDER_REFLECT = 2'd2;

    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_FROM_ROW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_COL_FROM_ROW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_FROM_COL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_COL_FROM_COL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BIAS          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_BIAS          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH         = 3'd7;

    typedef struct packed {
        logic signed [VAL_W-1:0] src_row;
        logic signed [VAL_W-1:0] src_col;
        logic                    mode;
        logic [1:0]              border;
    } wsg_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] fv;
        logic                    neg;
        logic                    crop;
        logic [K_W-1:0]          k;
    } wsg_axis_t;

    typedef struct packed {
        wsg_axis_t  row;
        wsg_axis_t  col;
        logic       mode;
        logic [1:0] border;
    } wsg_work_t;

    typedef struct packed {
        logic [COORD_W-1:0]   i0;
        logic [COORD_W-1:0]   i1;
        logic [FRAC_BITS-1:0] frac;
    } wsg_corner_t;

    function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        if (s < SIZE_W'(2))
            r = SIZE_W'(2);
        else if (s > SIZE_W'(MAX_DIM))
            r = SIZE_W'(MAX_DIM);
        else
            r = s;
        return r;
    endfunction

    function automatic wsg_axis_t axis_classify(input logic signed [VAL_W-1:0] v,
                                                input logic [SIZE_W-1:0] n,
                                                input logic mode,
                                                input logic [1:0] border);
        wsg_axis_t               a;
        logic signed [VAL_W-1:0] neg_v;
        logic signed [VAL_W-1:0] mag;
        logic signed [VAL_W-1:0] n_fx;
        logic signed [VAL_W-1:0] half;
        logic signed [VAL_W-1:0] one_m1;
        logic                    is_crop;
        neg_v  = -v;
        n_fx   = VAL_W'({n, {FRAC_BITS{1'b0}}});
        half   = VAL_W'(1) <<< (FRAC_BITS - 1);
        one_m1 = (VAL_W'(1) <<< FRAC_BITS) - VAL_W'(1);
        is_crop = (border == BORDER_CROP);
        a = '0;
        if (mode == MODE_NEAREST) begin
            if (v >= 0) begin
                mag   = (v + half) >>> FRAC_BITS;
                a.fv  = mag <<< FRAC_BITS;
                a.neg = 1'b0;
                a.k   = '0;
            end
            else begin
                mag   = (neg_v + half) >>> FRAC_BITS;
                a.fv  = -(mag <<< FRAC_BITS);
                a.neg = (mag != 0);
                a.k   = K_W'(mag);
            end
            a.crop = is_crop && (a.neg || (a.fv >= n_fx));
        end
        else begin
            mag    = (neg_v + one_m1) >>> FRAC_BITS;
            a.fv   = v;
            a.neg  = (v < 0);
            a.k    = K_W'(mag);
            a.crop = is_crop && ((v < -half) || (v >= n_fx - half));
        end
        return a;
    endfunction

    function automatic logic [K_W-1:0] mod_step(input logic [K_W-1:0] rem,
                                                input logic [MOD_W-1:0] m,
                                                input int s);
        logic [31:0] d;
        logic [31:0] r;
        d = 32'(m) << s;
        r = 32'(rem);
        if (r >= d)
            r = r - d;
        return K_W'(r);
    endfunction

    function automatic wsg_corner_t axis_resolve(input wsg_axis_t a,
                                                 input logic [K_W-1:0] rem,
                                                 input logic [SIZE_W-1:0] n,
                                                 input logic mode,
                                                 input logic [1:0] border);
        wsg_corner_t             c;
        logic signed [VAL_W-1:0] fv;
        logic signed [VAL_W-1:0] n_fx;
        logic signed [VAL_W-1:0] m_fx;
        logic signed [VAL_W-1:0] top_fx;
        logic [SIZE_W-1:0]       n1;
        logic [SIZE_W-1:0]       i0p;
        fv     = a.fv;
        n_fx   = VAL_W'({n, {FRAC_BITS{1'b0}}});
        m_fx   = n_fx + n_fx - (VAL_W'(2) <<< FRAC_BITS);
        top_fx = n_fx - (VAL_W'(1) <<< FRAC_BITS);
        case (border)
            BORDER_CROP:
            begin
                if (mode == MODE_BILINEAR && a.neg)
                    fv = '0;
            end
            BORDER_REFLECT:
            begin
                if (a.neg)
                    fv = VAL_W'({rem, {FRAC_BITS{1'b0}}});
                if (fv >= n_fx) begin
                    fv = m_fx - fv;
                    if (fv < 0)
                        fv = '0;
                end
            end
            default:
            begin
                if (fv < 0)
                    fv = '0;
                if (fv > top_fx)
                    fv = top_fx;
            end
        endcase
        n1     = n - SIZE_W'(1);
        c.i0   = fv[FRAC_BITS +: COORD_W];
        i0p    = SIZE_W'(c.i0) + SIZE_W'(1);
        if (mode == MODE_BILINEAR)
            c.i1 = (i0p > n1) ? n1[COORD_W-1:0] : i0p[COORD_W-1:0];
        else
            c.i1 = c.i0;
        c.frac = (mode == MODE_BILINEAR && c.i0 != c.i1) ? fv[FRAC_BITS-1:0] : '0;
        return c;
    endfunction

endpackage

// ----- hw/rtl/wsg_front.sv -----
// Front part: accepts a request and forms the source coordinates through the inverse matrix.
module wsg_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [wsg_pkg::COORD_W-1:0]           out_row,
    input  logic [wsg_pkg::COORD_W-1:0]           out_col,
    input  logic                                  mode,
    input  logic [1:0]                            border,
    input  logic signed [wsg_pkg::COEF_W-1:0]     coef_rr,
    input  logic signed [wsg_pkg::COEF_W-1:0]     coef_cr,
    input  logic signed [wsg_pkg::COEF_W-1:0]     coef_rc,
    input  logic signed [wsg_pkg::COEF_W-1:0]     coef_cc,
    input  logic signed [wsg_pkg::BIAS_W-1:0]     row_bias,
    input  logic signed [wsg_pkg::BIAS_W-1:0]     col_bias,
    input  logic                                  q_full,
    output logic                                  push,
    output wsg_pkg::wsg_item_t                    item
);

    logic                                 p_valid_reg;
    logic                                 p_valid_next;
    logic signed [wsg_pkg::PROD_W-1:0]    prod_rr_reg;
    logic signed [wsg_pkg::PROD_W-1:0]    prod_rc_reg;
    logic signed [wsg_pkg::PROD_W-1:0]    prod_cr_reg;
    logic signed [wsg_pkg::PROD_W-1:0]    prod_cc_reg;
    logic                                 mode_reg;
    logic [1:0]                           border_reg;
    logic                                 front_en;
    logic signed [wsg_pkg::COORD_W:0]     row_s;
    logic signed [wsg_pkg::COORD_W:0]     col_s;

    assign front_en     = !p_valid_reg || !q_full;
    assign in_stall     = !front_en;
    assign push         = p_valid_reg && !q_full;
    assign p_valid_next = front_en ? in_valid : p_valid_reg;
    assign row_s        = $signed({1'b0, out_row});
    assign col_s        = $signed({1'b0, out_col});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else
            p_valid_reg <= p_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (front_en && in_valid) begin
            prod_rr_reg <= coef_rr * row_s;
            prod_rc_reg <= coef_rc * col_s;
            prod_cr_reg <= coef_cr * row_s;
            prod_cc_reg <= coef_cc * col_s;
            mode_reg    <= mode;
            border_reg  <= border;
        end
    end

    always_comb
    begin
        item.src_row = wsg_pkg::VAL_W'(prod_rr_reg) + wsg_pkg::VAL_W'(prod_rc_reg)
                     + wsg_pkg::VAL_W'(row_bias);
        item.src_col = wsg_pkg::VAL_W'(prod_cr_reg) + wsg_pkg::VAL_W'(prod_cc_reg)
                     + wsg_pkg::VAL_W'(col_bias);
        item.mode    = mode_reg;
        item.border  = border_reg;
    end

endmodule

// ----- hw/rtl/wsg_queue.sv -----
// Two-entry queue between the front and back parts.
module wsg_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  wsg_pkg::wsg_item_t push_item,
    input  logic               pop,
    output wsg_pkg::wsg_item_t pop_item,
    output logic               full,
    output logic               empty
);

    wsg_pkg::wsg_item_t mem_reg [2];
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;

    assign full       = (count_reg == 2'd2);
    assign empty      = (count_reg == 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign count_next = count_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- hw/rtl/wsg_back.sv -----
// Back part: border rule, pipelined mirror modulo, corners, fractions and linear indices.
module wsg_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  wsg_pkg::wsg_item_t                  q_item,
    output logic                                pop,
    input  logic [wsg_pkg::SIZE_W-1:0]          height,
    input  logic [wsg_pkg::SIZE_W-1:0]          width,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                valid_res,
    output logic [wsg_pkg::INDEX_W-1:0]         index_near,
    output logic [wsg_pkg::INDEX_W-1:0]         index_far,
    output logic [wsg_pkg::FRAC_BITS-1:0]       frac_col,
    output logic [wsg_pkg::FRAC_BITS-1:0]       frac_row
);

    localparam int NS = wsg_pkg::MOD_STAGES;

    logic                          en;
    logic [wsg_pkg::MOD_W-1:0]     m_row;
    logic [wsg_pkg::MOD_W-1:0]     m_col;
    wsg_pkg::wsg_work_t            a_work;

    logic                          vld_reg     [NS+1];
    wsg_pkg::wsg_work_t            work_reg    [NS+1];
    logic [wsg_pkg::K_W-1:0]       rem_row_reg [NS+1];
    logic [wsg_pkg::K_W-1:0]       rem_col_reg [NS+1];

    logic                          f1_vld_reg;
    logic                          f1_ok_reg;
    wsg_pkg::wsg_corner_t          f1_row_reg;
    wsg_pkg::wsg_corner_t          f1_col_reg;

    logic                          f2_vld_reg;
    logic                          f2_ok_reg;
    logic [wsg_pkg::IDXP_W-1:0]    f2_pnear_reg;
    logic [wsg_pkg::IDXP_W-1:0]    f2_pfar_reg;
    logic [wsg_pkg::COORD_W-1:0]   f2_c0_reg;
    logic [wsg_pkg::COORD_W-1:0]   f2_c1_reg;
    logic [wsg_pkg::FRAC_BITS-1:0] f2_frow_reg;
    logic [wsg_pkg::FRAC_BITS-1:0] f2_fcol_reg;

    logic                          out_valid_reg;
    logic                          valid_res_reg;
    logic [wsg_pkg::INDEX_W-1:0]   index_near_reg;
    logic [wsg_pkg::INDEX_W-1:0]   index_far_reg;
    logic [wsg_pkg::FRAC_BITS-1:0] frac_col_reg;
    logic [wsg_pkg::FRAC_BITS-1:0] frac_row_reg;

    assign en    = !(out_valid_reg && out_stall);
    assign pop   = en && !q_empty;
    assign m_row = wsg_pkg::MOD_W'({height, 1'b0} - 2);
    assign m_col = wsg_pkg::MOD_W'({width, 1'b0} - 2);

    always_comb
    begin
        a_work.row    = wsg_pkg::axis_classify(q_item.src_row, height, q_item.mode,
                                               q_item.border);
        a_work.col    = wsg_pkg::axis_classify(q_item.src_col, width, q_item.mode,
                                               q_item.border);
        a_work.mode   = q_item.mode;
        a_work.border = q_item.border;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= !q_empty;
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            work_reg[0]    <= a_work;
            rem_row_reg[0] <= a_work.row.k;
            rem_col_reg[0] <= a_work.col.k;
        end
    end

    for (genvar j = 1; j <= NS; j++) begin : g_mod
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= vld_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                work_reg[j]    <= work_reg[j-1];
                rem_row_reg[j] <= wsg_pkg::mod_step(rem_row_reg[j-1], m_row, NS - j);
                rem_col_reg[j] <= wsg_pkg::mod_step(rem_col_reg[j-1], m_col, NS - j);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            f1_vld_reg    <= 1'b0;
            f2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en) begin
            f1_vld_reg    <= vld_reg[NS];
            f2_vld_reg    <= f1_vld_reg;
            out_valid_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            f1_ok_reg  <= !(work_reg[NS].row.crop || work_reg[NS].col.crop);
            f1_row_reg <= wsg_pkg::axis_resolve(work_reg[NS].row, rem_row_reg[NS], height,
                                                work_reg[NS].mode, work_reg[NS].border);
            f1_col_reg <= wsg_pkg::axis_resolve(work_reg[NS].col, rem_col_reg[NS], width,
                                                work_reg[NS].mode, work_reg[NS].border);

            f2_ok_reg    <= f1_ok_reg;
            f2_pnear_reg <= f1_row_reg.i0 * width;
            f2_pfar_reg  <= f1_row_reg.i1 * width;
            f2_c0_reg    <= f1_col_reg.i0;
            f2_c1_reg    <= f1_col_reg.i1;
            f2_frow_reg  <= f1_row_reg.frac;
            f2_fcol_reg  <= f1_col_reg.frac;

            valid_res_reg <= f2_ok_reg;
            if (f2_ok_reg) begin
                index_near_reg <= wsg_pkg::INDEX_W'(f2_pnear_reg + wsg_pkg::IDXP_W'(f2_c0_reg));
                index_far_reg  <= wsg_pkg::INDEX_W'(f2_pfar_reg + wsg_pkg::IDXP_W'(f2_c1_reg));
                frac_col_reg   <= f2_fcol_reg;
                frac_row_reg   <= f2_frow_reg;
            end
            else begin
                index_near_reg <= '0;
                index_far_reg  <= '0;
                frac_col_reg   <= '0;
                frac_row_reg   <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign valid_res  = valid_res_reg;
    assign index_near = index_near_reg;
    assign index_far  = index_far_reg;
    assign frac_col   = frac_col_reg;
    assign frac_row   = frac_row_reg;

endmodule

// ----- hw/rtl/warp_source_coordinate_generator.sv -----
// Top level: configuration registers, front part, queue and back part.
// Path: front products, queue, modulo stages, corner stage, index stage, result register.
// Throughput: one request per cycle when nothing stalls; the back pipeline holds as a whole
// while the result register is stalled, and the two-entry queue absorbs the front products.
// Reset: asynchronous, active low; clears all valid flags and loads the identity
// matrix, zero biases and a 64 by 64 source image.
module warp_source_coordinate_generator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [wsg_pkg::COORD_W-1:0]       out_row,
    input  logic [wsg_pkg::COORD_W-1:0]       out_col,
    input  logic                              mode,
    input  logic [1:0]                        border,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              valid_res,
    output logic [wsg_pkg::INDEX_W-1:0]       index_near,
    output logic [wsg_pkg::INDEX_W-1:0]       index_far,
    output logic [wsg_pkg::FRAC_BITS-1:0]     frac_col,
    output logic [wsg_pkg::FRAC_BITS-1:0]     frac_row,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wsg_pkg::BIAS_W-1:0]        cfg_data
);

    logic signed [wsg_pkg::COEF_W-1:0] coef_rr_reg;
    logic signed [wsg_pkg::COEF_W-1:0] coef_cr_reg;
    logic signed [wsg_pkg::COEF_W-1:0] coef_rc_reg;
    logic signed [wsg_pkg::COEF_W-1:0] coef_cc_reg;
    logic signed [wsg_pkg::BIAS_W-1:0] row_bias_reg;
    logic signed [wsg_pkg::BIAS_W-1:0] col_bias_reg;
    logic [wsg_pkg::SIZE_W-1:0]        height_reg;
    logic [wsg_pkg::SIZE_W-1:0]        width_reg;

    logic                              q_full;
    logic                              q_empty;
    logic                              push;
    logic                              pop;
    wsg_pkg::wsg_item_t                push_item;
    wsg_pkg::wsg_item_t                pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            coef_rr_reg  <= wsg_pkg::COEF_W'(4096);
            coef_cr_reg  <= '0;
            coef_rc_reg  <= '0;
            coef_cc_reg  <= wsg_pkg::COEF_W'(4096);
            row_bias_reg <= '0;
            col_bias_reg <= '0;
            height_reg   <= wsg_pkg::SIZE_W'(64);
            width_reg    <= wsg_pkg::SIZE_W'(64);
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                wsg_pkg::CFG_COEF_ROW_FROM_ROW: coef_rr_reg  <= cfg_data[wsg_pkg::COEF_W-1:0];
                wsg_pkg::CFG_COEF_COL_FROM_ROW: coef_cr_reg  <= cfg_data[wsg_pkg::COEF_W-1:0];
                wsg_pkg::CFG_COEF_ROW_FROM_COL: coef_rc_reg  <= cfg_data[wsg_pkg::COEF_W-1:0];
                wsg_pkg::CFG_COEF_COL_FROM_COL: coef_cc_reg  <= cfg_data[wsg_pkg::COEF_W-1:0];
                wsg_pkg::CFG_ROW_BIAS:          row_bias_reg <= cfg_data;
                wsg_pkg::CFG_COL_BIAS:          col_bias_reg <= cfg_data;
                wsg_pkg::CFG_SRC_HEIGHT:
                    height_reg <= wsg_pkg::sat_size(cfg_data[wsg_pkg::SIZE_W-1:0]);
                wsg_pkg::CFG_SRC_WIDTH:
                    width_reg  <= wsg_pkg::sat_size(cfg_data[wsg_pkg::SIZE_W-1:0]);
                default: ;
            endcase
        end
    end

    wsg_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_row  (out_row),
        .out_col  (out_col),
        .mode     (mode),
        .border   (border),
        .coef_rr  (coef_rr_reg),
        .coef_cr  (coef_cr_reg),
        .coef_rc  (coef_rc_reg),
        .coef_cc  (coef_cc_reg),
        .row_bias (row_bias_reg),
        .col_bias (col_bias_reg),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    wsg_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    wsg_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_item     (pop_item),
        .pop        (pop),
        .height     (height_reg),
        .width      (width_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .valid_res  (valid_res),
        .index_near (index_near),
        .index_far  (index_far),
        .frac_col   (frac_col),
        .frac_row   (frac_row)
    );

endmodule

// ----- hw/rtl/wsg_checker.sv -----
// Port-level checker for the warp source coordinate generator, bound to the top level.
module wsg_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic [wsg_pkg::COORD_W-1:0]       out_row,
    input logic [wsg_pkg::COORD_W-1:0]       out_col,
    input logic                              mode,
    input logic [1:0]                        border,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              valid_res,
    input logic [wsg_pkg::INDEX_W-1:0]       index_near,
    input logic [wsg_pkg::INDEX_W-1:0]       index_far,
    input logic [wsg_pkg::FRAC_BITS-1:0]     frac_col,
    input logic [wsg_pkg::FRAC_BITS-1:0]     frac_row,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [wsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [wsg_pkg::BIAS_W-1:0]        cfg_data
);

    a_crop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> index_near == '0 && index_far == '0
                                    && frac_col == '0 && frac_row == '0)
        else $error("cropped result carries nonzero payload");

    a_far_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> index_far >= index_near)
        else $error("far corner precedes near corner");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(index_near) && $stable(valid_res))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind warp_source_coordinate_generator wsg_checker u_wsg_checker (.*);
